>>> hdl/mau_pkg.sv
// ----------------------------------------------------------------------------
// mau_pkg: shared types and constants for the multi-turn angle unwrapper
// Field widths, register indexes and reset values of the configuration set.
// ----------------------------------------------------------------------------
package mau_pkg;

  localparam int unsigned AngleW = 14;
  localparam int unsigned PosW   = 32;
  localparam int unsigned DivW   = 14;
  localparam int unsigned HystW  = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 14;

  // angle modulus is 2**AngleW
  localparam int unsigned DeltaW = AngleW + 2;

  typedef logic [AngleW-1:0]        angle_t;
  typedef logic signed [PosW-1:0]   pos_t;
  typedef logic [DivW-1:0]          div_t;
  typedef logic [HystW-1:0]         hyst_t;
  typedef logic [CfgIdxW-1:0]       cfg_idx_t;
  typedef logic [CfgDataW-1:0]      cfg_data_t;

  // configuration register indexes
  localparam cfg_idx_t RegEnable = 3'd0;
  localparam cfg_idx_t RegWrapHi = 3'd1;
  localparam cfg_idx_t RegWrapLo = 3'd2;
  localparam cfg_idx_t RegCpd    = 3'd3;
  localparam cfg_idx_t RegHyst   = 3'd4;

  // reset values
  localparam angle_t RstWrapHi = 14'd12384;
  localparam angle_t RstWrapLo = 14'd4000;
  localparam div_t   RstCpd    = 14'd200;
  localparam hyst_t  RstHyst   = 8'd6;

endpackage

>>> hdl/mau_if.sv
// ----------------------------------------------------------------------------
// mau_if: valid/ready stream interfaces
// Input sample channel and result channel of the angle unwrapper.
// ----------------------------------------------------------------------------
interface mau_in_if
  import mau_pkg::*;
();
  logic   valid;
  logic   ready;
  angle_t angle;
  logic   restart;

  modport source (output valid, output angle, output restart, input ready);
  modport sink   (input valid, input angle, input restart, output ready);
endinterface

interface mau_out_if
  import mau_pkg::*;
();
  logic valid;
  logic ready;
  pos_t position;
  pos_t detent;
  logic step_down;
  logic step_up;

  modport source (output valid, output position, output detent,
                  output step_down, output step_up, input ready);
  modport sink   (input valid, input position, input detent,
                  input step_down, input step_up, output ready);
endinterface

>>> hdl/multiturn_angle_unwrap_detent.sv
// ----------------------------------------------------------------------------
// multiturn_angle_unwrap_detent: multi-turn angle unwrapper with detent events
// Accumulates a saturating signed position from 14-bit absolute angles and
// reports the detent number with hysteresis-filtered step events.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake      payload
//  -------  ---  -------------  -----------------------------------------
//  in_i     in   valid/ready    angle[13:0], restart
//  out_o    out  valid/ready    position[31:0], detent[31:0], step_down,
//                               step_up
//  cfg      in   cfg_we_i       cfg_idx_i[2:0], cfg_data_i[13:0]
//
//  Each sample passes these steps from transfer to registered result:
//  update the position, load the divider, form the 32-bit quotient bit
//  by bit, see the divider finish, sign the detent and run the hysteresis
//  compare. The radix-2 divider takes most of this time. The next input
//  transfer can follow once the sequencer is back in idle after the compare.
//  A waiting result does not block the next input transfer; only the final
//  compare step waits for the output register to drain.
//  Reset (async, active low) restores register defaults and clears state.
// ----------------------------------------------------------------------------
module multiturn_angle_unwrap_detent
  import mau_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  cfg_idx_t   cfg_idx_i,
  input  cfg_data_t  cfg_data_i,
  mau_in_if.sink     in_i,
  mau_out_if.source  out_o
);

  // sequencer codes
  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SUpd   = 3'd1;
  localparam logic [2:0] SStart = 3'd2;
  localparam logic [2:0] SDiv   = 3'd3;
  localparam logic [2:0] SFin   = 3'd4;
  localparam logic [2:0] SCmp   = 3'd5;

  // configuration registers
  logic   en_q;
  angle_t wrap_hi_q, wrap_lo_q;
  div_t   cpd_q;
  hyst_t  hyst_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q      <= 1'b1;
      wrap_hi_q <= RstWrapHi;
      wrap_lo_q <= RstWrapLo;
      cpd_q     <= RstCpd;
      hyst_q    <= RstHyst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegEnable: en_q      <= cfg_data_i[0];
        RegWrapHi: wrap_hi_q <= cfg_data_i[AngleW-1:0];
        RegWrapLo: wrap_lo_q <= cfg_data_i[AngleW-1:0];
        RegCpd:    cpd_q     <= cfg_data_i[DivW-1:0];
        RegHyst:   hyst_q    <= cfg_data_i[HystW-1:0];
        default: ;
      endcase
    end
  end

  // control and state
  logic [2:0] state_q, state_d;
  logic       init_q, init_d;
  angle_t     last_q, last_d;
  pos_t       pos_q, pos_d;
  pos_t       rep_q, rep_d;
  logic       evt_q, evt_d;       // hysteresis events allowed for this sample
  logic       neg_q, neg_d;       // position negative: negate quotient
  pos_t       det_q, det_d;

  // sample latched at transfer
  angle_t     ang_q;
  logic       rst_smp_q;
  logic       en_smp_q;

  // output register
  logic       ovld_q, ovld_d;
  pos_t       opos_q, odet_q;
  logic       odn_q, oup_q;

  logic       in_fire, out_fire;
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = ovld_q && out_o.ready;

  // divider
  logic            div_start, div_busy, div_done;
  logic [PosW-1:0] div_dvd, div_quot;
  div_t            div_dvs;

  assign div_start = (state_q == SStart);
  assign div_dvd   = pos_q[PosW-1] ? (PosW)'(-pos_q) : pos_q;
  assign div_dvs   = (cpd_q == '0) ? div_t'(1) : cpd_q;

  mau_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // unwrap delta: forward wrap past zero, backward wrap, or plain step
  logic                     wrap_fwd, wrap_bwd;
  logic signed [DeltaW-1:0] delta;
  logic signed [PosW:0]     sum;
  pos_t                     pos_sat;

  assign wrap_fwd = (ang_q < last_q) && (last_q > wrap_hi_q) && (ang_q < wrap_lo_q);
  assign wrap_bwd = (ang_q > last_q) && (last_q < wrap_lo_q) && (ang_q > wrap_hi_q);

  always_comb begin
    delta = $signed({2'b00, ang_q}) - $signed({2'b00, last_q});
    if (wrap_fwd) begin
      delta = delta + $signed(DeltaW'(1 << AngleW));
    end else if (wrap_bwd) begin
      delta = delta - $signed(DeltaW'(1 << AngleW));
    end
  end

  // saturating accumulate on 33 bits
  assign sum = {pos_q[PosW-1], pos_q} + (PosW+1)'(delta);
  always_comb begin
    if (sum[PosW] != sum[PosW-1]) begin
      pos_sat = sum[PosW] ? {1'b1, {(PosW-1){1'b0}}} : {1'b0, {(PosW-1){1'b1}}};
    end else begin
      pos_sat = sum[PosW-1:0];
    end
  end

  // hysteresis compare
  logic signed [PosW:0] diff, hyst_ext;
  logic                 go_dn, go_up;
  assign diff     = {det_q[PosW-1], det_q} - {rep_q[PosW-1], rep_q};
  assign hyst_ext = (PosW+1)'(hyst_q);
  assign go_dn    = evt_q && (diff > hyst_ext);
  assign go_up    = evt_q && (diff < -hyst_ext);

  always_comb begin
    state_d = state_q;
    init_d  = init_q;
    last_d  = last_q;
    pos_d   = pos_q;
    rep_d   = rep_q;
    evt_d   = evt_q;
    neg_d   = neg_q;
    det_d   = det_q;
    ovld_d  = ovld_q && !out_fire;
    case (state_q)
      SIdle: begin
        if (in_fire) begin
          state_d = SUpd;
        end
      end
      SUpd: begin
        evt_d = 1'b0;
        if (en_smp_q) begin
          if (!init_q || rst_smp_q) begin
            last_d = ang_q;
            pos_d  = '0;
            init_d = 1'b1;
          end else begin
            last_d = ang_q;
            pos_d  = pos_sat;
            evt_d  = 1'b1;
          end
        end
        state_d = SStart;
      end
      SStart: begin
        neg_d   = pos_q[PosW-1];
        state_d = SDiv;
      end
      SDiv: begin
        if (div_done) begin
          state_d = SFin;
        end
      end
      SFin: begin
        det_d   = neg_q ? (PosW)'(-div_quot) : div_quot;
        state_d = SCmp;
      end
      SCmp: begin
        if (!ovld_q || out_fire) begin
          ovld_d = 1'b1;
          if (go_dn || go_up) begin
            rep_d = det_q;
          end
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      init_q  <= 1'b0;
      last_q  <= '0;
      pos_q   <= '0;
      rep_q   <= '0;
      evt_q   <= 1'b0;
      neg_q   <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      last_q  <= last_d;
      pos_q   <= pos_d;
      rep_q   <= rep_d;
      evt_q   <= evt_d;
      neg_q   <= neg_d;
      ovld_q  <= ovld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    det_q <= det_d;
    if (in_fire) begin
      ang_q     <= in_i.angle;
      rst_smp_q <= in_i.restart;
      en_smp_q  <= en_q;
    end
    if (state_q == SCmp && (!ovld_q || out_fire)) begin
      opos_q <= pos_q;
      odet_q <= det_q;
      odn_q  <= go_dn;
      oup_q  <= go_up;
    end
  end

  assign in_i.ready      = (state_q == SIdle);
  assign out_o.valid     = ovld_q;
  assign out_o.position  = opos_q;
  assign out_o.detent    = odet_q;
  assign out_o.step_down = odn_q;
  assign out_o.step_up   = oup_q;

  // checks
  a_idle_div_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SIdle) |-> !div_busy)
    else $error("divider busy while sequencer idle");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == SDiv))
    else $error("divider finished outside the divide phase");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == SUpd))
    else $error("accepted sample did not start the update");

  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovld_q |-> !(odn_q && oup_q))
    else $error("both step events raised together");

endmodule

>>> hdl/mau_div.sv
// ----------------------------------------------------------------------------
// mau_div: radix-2 restoring divider
// Unsigned 32-bit dividend by 14-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mau_div
  import mau_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [PosW-1:0] dividend_i,
  input  div_t            divisor_i,
  output logic            busy_o,
  output logic            done_o,
  output logic [PosW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(PosW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  div_t            rem_q, rem_d;
  logic [PosW-1:0] quo_q, quo_d;
  div_t            dvs_q, dvs_d;

  logic [DivW:0]   shifted;
  logic [DivW+1:0] trial;
  logic            ge;

  assign shifted = {rem_q, quo_q[PosW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_q};
  assign ge      = ~trial[DivW+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? trial[DivW-1:0] : shifted[DivW-1:0];
      quo_d = {quo_q[PosW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(PosW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

>>> tb/multiturn_angle_unwrap_detent_tb.sv
// ----------------------------------------------------------------------------
// multiturn_angle_unwrap_detent_tb: self-checking bench for the angle unwrapper
// Drives angle samples through the valid/ready input channel and checks each
// result transfer against a cycle-free model of the unwrap, the saturating
// accumulation, the detent division and the hysteresis events. A short table
// of directed samples runs first. Randomised phases follow, each under its
// own register setting, with random gaps on both channels in most of them.
// ----------------------------------------------------------------------------
module multiturn_angle_unwrap_detent_tb;
  import mau_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Longest run of cycles with no transfer of any kind before the run is
  // abandoned. One sample costs at most the longest random input gap, its
  // processing and the longest output stall, so this is many times over.
  localparam int unsigned StallLimit = 1000;
  // Quiet cycles after the last result, to catch any stray result.
  localparam int unsigned TailCycles = 40;
  localparam int unsigned NumPhases  = 13;
  localparam int unsigned NumDirRows = 21;

  typedef struct packed {
    pos_t position;
    pos_t detent;
    logic step_down;
    logic step_up;
  } track_res_t;

  // One directed sample. Where typed is set the result is written in by hand,
  // otherwise it comes from the tracking model.
  typedef struct packed {
    angle_t angle;
    logic   restart;
    logic   typed;
    pos_t   position;
    pos_t   detent;
    logic   step_down;
    logic   step_up;
  } dir_row_t;

  // Walked under the reset setting: high threshold 12384, low 4000,
  // 200 counts per detent, hysteresis 6.
  localparam dir_row_t DirRows [NumDirRows] = '{
    // first sample after reset only captures the angle
    '{14'd16383, 1'b0, 1'b1, 32'sd0, 32'sd0, 1'b0, 1'b0},
    // forward wrap past zero by a single count
    '{14'd0,     1'b0, 1'b1, 32'sd1, 32'sd0, 1'b0, 1'b0},
    // and straight back again
    '{14'd16383, 1'b0, 1'b1, 32'sd0, 32'sd0, 1'b0, 1'b0},
    '{14'd13000, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0, 1'b0},
    '{14'd1000,  1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0, 1'b0},
    '{14'd3999,  1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0, 1'b0},
    '{14'd4000,  1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0, 1'b0},
    '{14'd12384, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0, 1'b0},
    '{14'd12385, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0, 1'b0},
    '{14'd0,     1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0, 1'b0},
    '{14'd12385, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0, 1'b0},
    // restart: recapture, position back to zero
    '{14'd8192,  1'b1, 1'b1, 32'sd0, 32'sd0, 1'b0, 1'b0},
    '{14'd16383, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0, 1'b0},
    '{14'd0,     1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0, 1'b0},
    '{14'd5000,  1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0, 1'b0},
    '{14'd3000,  1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0, 1'b0},
    '{14'd16383, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0, 1'b0},
    '{14'd0,     1'b1, 1'b1, 32'sd0, 32'sd0, 1'b0, 1'b0},
    // no movement at all
    '{14'd0,     1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0, 1'b0},
    // alternating bit patterns
    '{14'd10922, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0, 1'b0},
    '{14'd5461,  1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0, 1'b0}
  };

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      cfg_we_i;
  cfg_idx_t  cfg_idx_i;
  cfg_data_t cfg_data_i;

  mau_in_if  in_if ();
  mau_out_if out_if ();

  multiturn_angle_unwrap_detent i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Tracking model: register copy and unwrap state
  // --------------------------------------------------------------------------
  logic   cfg_en      = 1'b1;
  angle_t cfg_wrap_hi = RstWrapHi;
  angle_t cfg_wrap_lo = RstWrapLo;
  div_t   cfg_cpd     = RstCpd;
  hyst_t  cfg_hyst    = RstHyst;

  angle_t trk_last_angle = '0;
  longint trk_pos        = 0;   // kept wide so the clamp can be applied
  longint trk_reported   = 0;   // last detent that raised an event
  bit     trk_primed     = 1'b0;

  track_res_t pending_results [$];
  int         mismatches  = 0;
  int         quiet_cycles = 0;
  bit         src_idle = 1'b1;  // sender inserts random gaps
  bit         snk_idle = 1'b1;  // receiver inserts random stalls
  angle_t     drv_angle = '0;   // last angle handed to the block

  // Works out the result of one accepted sample and moves the model on.
  function automatic track_res_t advance_position(angle_t ang, logic rs);
    track_res_t res;
    longint     prev;
    longint     cur;
    longint     divisor;
    longint     delta;
    longint     det;
    longint     diff;
    longint     hyst;
    res     = '0;
    prev    = longint'(trk_last_angle);
    cur     = longint'(ang);
    divisor = (cfg_cpd == '0) ? 64'sd1 : longint'(cfg_cpd);
    hyst    = longint'(cfg_hyst);

    // disabled: everything holds, the held position is reported
    if (!cfg_en) begin
      res.position = pos_t'(trk_pos);
      res.detent   = pos_t'(trk_pos / divisor);
      return res;
    end

    // capture: first sample or restart, reported detent left alone
    if (!trk_primed || rs) begin
      trk_last_angle = ang;
      trk_pos        = 0;
      trk_primed     = 1'b1;
      return res;
    end

    if (ang < trk_last_angle && trk_last_angle > cfg_wrap_hi && ang < cfg_wrap_lo) begin
      delta = 64'sd16384 - prev + cur;
    end else if (ang > trk_last_angle && trk_last_angle < cfg_wrap_lo &&
                 ang > cfg_wrap_hi) begin
      delta = -(64'sd16384 - cur + prev);
    end else begin
      delta = cur - prev;
    end
    trk_last_angle = ang;

    // Saturation needs some 131k full-range samples, well past this run's
    // length, so the clamp is modelled but not driven into.
    trk_pos = trk_pos + delta;
    if (trk_pos > 64'sd2147483647) trk_pos = 64'sd2147483647;
    if (trk_pos < -64'sd2147483648) trk_pos = -64'sd2147483648;

    det  = trk_pos / divisor;   // truncates toward zero
    diff = det - trk_reported;
    if (diff > hyst) begin
      res.step_down = 1'b1;
      trk_reported  = det;
    end else if (diff < -hyst) begin
      res.step_up  = 1'b1;
      trk_reported = det;
    end
    res.position = pos_t'(trk_pos);
    res.detent   = pos_t'(det);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------

  // Offers one sample and waits for its transfer. valid is left high, so a
  // following sample with no gap is offered straight away, without valid dropping.
  task automatic push_sample(angle_t ang, logic rs, logic typed, track_res_t typed_res);
    int         gap;
    track_res_t pred;
    gap = src_idle ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.angle   <= ang;
    in_if.restart <= rs;
    do @(posedge clk_i); while (!in_if.ready);
    pred = advance_position(ang, rs);
    pending_results.push_back(typed ? typed_res : pred);
    drv_angle = ang;
  endtask

  // Drops valid and holds off until every pending result has come back.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      RegEnable: cfg_en      = val[0];
      RegWrapHi: cfg_wrap_hi = angle_t'(val);
      RegWrapLo: cfg_wrap_lo = angle_t'(val);
      RegCpd:    cfg_cpd     = div_t'(val);
      RegHyst:   cfg_hyst    = hyst_t'(val);
      default: ;
    endcase
  endtask

  // Only called with the block idle: valid low and nothing pending.
  task automatic apply_settings(logic en, angle_t hi, angle_t lo, div_t cpd, hyst_t hy);
    write_reg(RegEnable, cfg_data_t'(en));
    write_reg(RegWrapHi, cfg_data_t'(hi));
    write_reg(RegWrapLo, cfg_data_t'(lo));
    write_reg(RegCpd,    cfg_data_t'(cpd));
    write_reg(RegHyst,   cfg_data_t'(hy));
    cfg_we_i <= 1'b0;
  endtask

  // Mostly smooth rotation by up to span counts either way, which runs the
  // angle round through zero in both directions; the rest is random angles,
  // the threshold edges, half-turn jumps and stray restarts.
  task automatic run_random(int n, int span);
    int     pick;
    int     step;
    angle_t ang;
    logic   rs;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      rs   = 1'b0;
      if (pick < 70) begin
        step = int'($urandom_range(0, 2 * span)) - span;
        ang  = angle_t'(int'(drv_angle) + step);
      end else if (pick < 80) begin
        ang = angle_t'($urandom);
      end else if (pick < 88) begin
        case ($urandom_range(0, 5))
          0:       ang = '0;
          1:       ang = '1;
          2:       ang = cfg_wrap_hi;
          3:       ang = cfg_wrap_hi + 1'b1;
          4:       ang = cfg_wrap_lo;
          default: ang = cfg_wrap_lo - 1'b1;
        endcase
      end else if (pick < 92) begin
        ang = angle_t'($urandom);
        rs  = 1'b1;
      end else begin
        ang = drv_angle ^ 14'h2000;
      end
      if (pick >= 92 && $urandom_range(0, 9) == 0) rs = 1'b1;
      push_sample(ang, rs, 1'b0, '0);
      // now and then the sender waits for the pipeline to run dry
      if ($urandom_range(0, 49) == 0) drain_results();
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  initial begin : result_sink
    int         stall;
    track_res_t want;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = snk_idle ? $urandom_range(0, 17) : 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (out_if.valid !== 1'b1);
      if (pending_results.size() == 0) begin
        $display("%0t: result transfer with nothing pending, position %0d detent %0d",
                 $time, out_if.position, out_if.detent);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("position",  want.position,  out_if.position);
        check_field("detent",    want.detent,    out_if.detent);
        check_field("step_down", 32'(want.step_down), 32'(out_if.step_down));
        check_field("step_up",   32'(want.step_up),   32'(out_if.step_up));
      end
    end
  end

  // Watchdog: any transfer or register write counts as progress.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: no transfer for %0d cycles, %0d results pending",
               $time, quiet_cycles, pending_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int         span;
    logic       en;
    angle_t     hi;
    angle_t     lo;
    div_t       cpd;
    hyst_t      hy;
    track_res_t row_res;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_data_i    <= '0;
    in_if.valid   <= 1'b0;
    in_if.angle   <= '0;
    in_if.restart <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed samples under the reset setting
    for (int i = 0; i < NumDirRows; i++) begin
      row_res = '{DirRows[i].position, DirRows[i].detent,
                  DirRows[i].step_down, DirRows[i].step_up};
      push_sample(DirRows[i].angle, DirRows[i].restart, DirRows[i].typed, row_res);
    end
    drain_results();

    // disabled straight after: the directed position must hold
    apply_settings(1'b0, RstWrapHi, RstWrapLo, RstCpd, RstHyst);
    run_random(12, 600);
    drain_results();

    for (int ph = 0; ph < NumPhases; ph++) begin
      case ($urandom_range(0, 3))
        0:       span = 3;
        1:       span = 60;
        2:       span = 900;
        default: span = 4000;
      endcase
      case (ph)
        // thresholds at the far ends: no wrap can ever fire, detent = position
        0: begin en = 1'b1; hi = '1; lo = '0; cpd = div_t'(1); hy = '0; end
        // thresholds crossed over: wrap regions overlap the plain steps
        1: begin en = 1'b1; hi = '0; lo = '1; cpd = '1; hy = '1; end
        // zero divisor, taken as one
        2: begin en = 1'b1; hi = RstWrapHi; lo = RstWrapLo; cpd = '0; hy = '0; end
        // disabled part way through, with a non-zero position held
        3: begin
          en  = 1'b0;
          hi  = angle_t'($urandom);
          lo  = angle_t'($urandom);
          cpd = div_t'($urandom_range(1, 500));
          hy  = hyst_t'($urandom);
        end
        4: begin en = 1'b1; hi = RstWrapHi; lo = RstWrapLo; cpd = div_t'(1); hy = '1; end
        default: begin
          en  = ($urandom_range(0, 7) != 0);
          hi  = ($urandom_range(0, 3) == 0) ? angle_t'($urandom)
                                            : angle_t'($urandom_range(8192, 16383));
          lo  = ($urandom_range(0, 3) == 0) ? angle_t'($urandom)
                                            : angle_t'($urandom_range(0, 8191));
          case ($urandom_range(0, 4))
            0, 1:    cpd = div_t'($urandom_range(1, 16));
            2, 3:    cpd = div_t'($urandom_range(1, 1000));
            default: cpd = div_t'($urandom);
          endcase
          hy  = ($urandom_range(0, 1) == 0) ? hyst_t'($urandom_range(0, 8)) : hyst_t'($urandom);
        end
      endcase
      // some phases run flat out on one side or both
      src_idle = ($urandom_range(0, 3) != 0);
      snk_idle = ($urandom_range(0, 3) != 0);
      apply_settings(en, hi, lo, cpd, hy);
      run_random((ph == 3) ? 15 : 55, span);
      drain_results();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
